>>> hdl/ispt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the IR spot pan/tilt tracker.
// Used by ispt_cfg, ispt_axis and ir_spot_pan_tilt_tracker; no dependencies.
package ispt_pkg;

	localparam int unsigned CoordW = 10;
	localparam int unsigned SizeW  = 8;
	localparam int unsigned StepW  = 4;
	localparam int unsigned PosW   = 10;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 10;

	localparam logic [CoordW-1:0] CoordMax  = 10'd1023;
	localparam logic [SizeW-1:0]  SizeNone  = 8'd255;
	localparam logic [CoordW-1:0] YLimit    = 10'd768;
	localparam logic [PosW-1:0]   PosMax    = 10'd1023;
	localparam logic [PosW-1:0]   PanReset  = 10'd100;
	localparam logic [PosW-1:0]   TiltReset = 10'd130;

	typedef enum logic [CfgIdxW-1:0] {
		REG_DEADBAND     = 3'd0,
		REG_SMALL_LIMIT  = 3'd1,
		REG_MEDIUM_LIMIT = 3'd2,
		REG_CENTER_X     = 3'd3,
		REG_CENTER_Y     = 3'd4,
		REG_STEP_SMALL   = 3'd5,
		REG_STEP_MEDIUM  = 3'd6,
		REG_STEP_LARGE   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [CoordW-1:0] deadband;
		logic [CoordW-1:0] small_limit;
		logic [CoordW-1:0] medium_limit;
		logic [CoordW-1:0] center_x;
		logic [CoordW-1:0] center_y;
		logic [StepW-1:0]  step_small;
		logic [StepW-1:0]  step_medium;
		logic [StepW-1:0]  step_large;
	} cfg_t;

	typedef struct packed {
		logic [CoordW-1:0] spot_x;
		logic [CoordW-1:0] spot_y;
		logic [SizeW-1:0]  spot_size;
		logic              hold_vertical;
	} spot_t;

	typedef struct packed {
		logic            detected;
		logic [PosW-1:0] pan_position;
		logic [PosW-1:0] tilt_position;
		logic            pan_moved;
		logic            tilt_moved;
	} track_t;

	// per-axis decision handed back to the top level
	typedef struct packed {
		logic            take;
		logic            moved;
		logic [PosW-1:0] pos_next;
	} axis_res_t;

endpackage

>>> hdl/ispt_cfg.sv
`timescale 1ns / 1ps
// Configuration register file of the tracker: eight registers written by index.
// Depends on ispt_pkg.
module ispt_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ispt_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [ispt_pkg::CfgDataW-1:0]  cfg_data,
	output ispt_pkg::cfg_t                 cfg
);

	ispt_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadband     <= 10'd10;
			cfg_q.small_limit  <= 10'd40;
			cfg_q.medium_limit <= 10'd100;
			cfg_q.center_x     <= 10'd500;
			cfg_q.center_y     <= 10'd362;
			cfg_q.step_small   <= 4'd1;
			cfg_q.step_medium  <= 4'd3;
			cfg_q.step_large   <= 4'd5;
		end else if (cfg_valid && cfg_ready) begin
			case (ispt_pkg::cfg_reg_t'(cfg_index))
				ispt_pkg::REG_DEADBAND:     cfg_q.deadband     <= cfg_data;
				ispt_pkg::REG_SMALL_LIMIT:  cfg_q.small_limit  <= cfg_data;
				ispt_pkg::REG_MEDIUM_LIMIT: cfg_q.medium_limit <= cfg_data;
				ispt_pkg::REG_CENTER_X:     cfg_q.center_x     <= cfg_data;
				ispt_pkg::REG_CENTER_Y:     cfg_q.center_y     <= cfg_data;
				ispt_pkg::REG_STEP_SMALL:   cfg_q.step_small   <= cfg_data[ispt_pkg::StepW-1:0];
				ispt_pkg::REG_STEP_MEDIUM:  cfg_q.step_medium  <= cfg_data[ispt_pkg::StepW-1:0];
				ispt_pkg::REG_STEP_LARGE:   cfg_q.step_large   <= cfg_data[ispt_pkg::StepW-1:0];
				default: ;
			endcase
		end
	end

endmodule

>>> hdl/ispt_axis.sv
`timescale 1ns / 1ps
// One servo axis: deadband test, step choice and saturating position update.
// Pure combinational; depends on ispt_pkg.
module ispt_axis (
	input  ispt_pkg::cfg_t                 cfg,
	input  logic                           enable,
	input  logic [ispt_pkg::CoordW-1:0]    coord,
	input  logic [ispt_pkg::CoordW-1:0]    last,
	input  logic [ispt_pkg::PosW-1:0]      pos,
	input  logic                           dir_up,
	output ispt_pkg::axis_res_t            res
);

	logic [ispt_pkg::CoordW-1:0] diff;
	logic [ispt_pkg::StepW-1:0]  step;
	logic [ispt_pkg::PosW:0]     sum;
	logic [ispt_pkg::PosW-1:0]   pos_up;
	logic [ispt_pkg::PosW-1:0]   pos_dn;

	always_comb begin
		diff = (coord > last) ? (coord - last) : (last - coord);

		if (diff <= cfg.small_limit)
			step = cfg.step_small;
		else if (diff <= cfg.medium_limit)
			step = cfg.step_medium;
		else
			step = cfg.step_large;

		sum    = {1'b0, pos} + {{(ispt_pkg::PosW + 1 - ispt_pkg::StepW){1'b0}}, step};
		pos_up = (sum > {1'b0, ispt_pkg::PosMax}) ? ispt_pkg::PosMax : sum[ispt_pkg::PosW-1:0];
		// clamp at zero when the step exceeds the position
		pos_dn = ({{(ispt_pkg::PosW - ispt_pkg::StepW){1'b0}}, step} > pos) ? '0
			: pos - {{(ispt_pkg::PosW - ispt_pkg::StepW){1'b0}}, step};

		res.take     = enable && (diff > cfg.deadband);
		res.pos_next = res.take ? (dir_up ? pos_up : pos_dn) : pos;
		res.moved    = res.pos_next != pos;
	end

endmodule

>>> hdl/ir_spot_pan_tilt_tracker.sv
`timescale 1ns / 1ps
// IR spot pan/tilt tracker, top level.
// Depends on ispt_pkg, ispt_cfg and ispt_axis.
//
// Spot reports enter on in_valid/in_stall/in_data; one tracking result per
// report leaves on out_valid/out_stall/out_data. A report is taken at an edge
// where valid is high and stall is low, on either channel.
// An accepted report is written to the input register; its result is written to
// the result register as the report leaves it. Throughput is one report per cycle
// while out_stall is low; the servo state is updated as the report moves between
// the two registers, so consecutive reports see each other's result.
// A result waiting on a stalled receiver does not block the input register:
// one more report is taken and parked there; in_stall rises only when both
// registers are full and out_stall is high.
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
// is always high. Write only while no report is in flight.
// Reset (arst_n low) empties both registers, restores the default register
// values and sets pan to 100, tilt to 130 and the last accepted spot to 0.
module ir_spot_pan_tilt_tracker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  ispt_pkg::spot_t                in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output ispt_pkg::track_t               out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ispt_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [ispt_pkg::CfgDataW-1:0]  cfg_data
);

	ispt_pkg::cfg_t    cfg;
	ispt_pkg::spot_t   data_s1;
	logic              valid_s1;
	ispt_pkg::track_t  out_data_q;
	logic              out_valid_q;

	logic [ispt_pkg::CoordW-1:0] last_x_q;
	logic [ispt_pkg::CoordW-1:0] last_y_q;
	logic [ispt_pkg::PosW-1:0]   pan_q;
	logic [ispt_pkg::PosW-1:0]   tilt_q;

	logic                out_ready;
	logic                fire_s1;
	logic                present;
	logic                pan_en;
	logic                tilt_en;
	ispt_pkg::axis_res_t pan_res;
	ispt_pkg::axis_res_t tilt_res;
	ispt_pkg::track_t    result;

	ispt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign out_ready = !out_valid_q || !out_stall;
	assign fire_s1   = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		present = !(data_s1.spot_x == ispt_pkg::CoordMax &&
			data_s1.spot_y == ispt_pkg::CoordMax &&
			data_s1.spot_size == ispt_pkg::SizeNone);
		pan_en  = present && (data_s1.spot_x != '0) &&
			(data_s1.spot_x != ispt_pkg::CoordMax);
		tilt_en = present && !data_s1.hold_vertical && (data_s1.spot_y != '0) &&
			(data_s1.spot_y <= ispt_pkg::YLimit);
	end

	ispt_axis u_pan (
		.cfg    (cfg),
		.enable (pan_en),
		.coord  (data_s1.spot_x),
		.last   (last_x_q),
		.pos    (pan_q),
		.dir_up (data_s1.spot_x >= cfg.center_x),
		.res    (pan_res)
	);

	// tilt runs the other way: spot above the centre line raises tilt
	ispt_axis u_tilt (
		.cfg    (cfg),
		.enable (tilt_en),
		.coord  (data_s1.spot_y),
		.last   (last_y_q),
		.pos    (tilt_q),
		.dir_up (data_s1.spot_y < cfg.center_y),
		.res    (tilt_res)
	);

	always_comb begin
		result.detected      = present;
		result.pan_position  = pan_res.pos_next;
		result.tilt_position = tilt_res.pos_next;
		result.pan_moved     = pan_res.moved;
		result.tilt_moved    = tilt_res.moved;
	end

	// input register: take a new item whenever the slot is empty or drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	// servo state advances only when the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
			pan_q    <= ispt_pkg::PanReset;
			tilt_q   <= ispt_pkg::TiltReset;
		end else if (fire_s1) begin
			if (pan_res.take)
				last_x_q <= data_s1.spot_x;
			if (tilt_res.take)
				last_y_q <= data_s1.spot_y;
			pan_q  <= pan_res.pos_next;
			tilt_q <= tilt_res.pos_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_data_q <= result;
		end
	end

	a_no_spot_no_move: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.detected) |-> (!out_data.pan_moved && !out_data.tilt_moved))
		else $error("servo moved on a report without a spot");

	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.pan_position == pan_q && out_data.tilt_position == tilt_q))
		else $error("shown result disagrees with servo state");

	a_hold_freezes_tilt: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && data_s1.hold_vertical) |=> ($stable(tilt_q) && $stable(last_y_q)))
		else $error("tilt changed while held");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with a free register");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for ir_spot_pan_tilt_tracker: directed and random spot reports,
// a servo position predictor in a scoreboard class, randomized idle and stall phases.
// Depends on ispt_pkg and the tracker RTL only.
module tb_top;
	import ispt_pkg::*;

	localparam int CycleLimit = 300000;

	class track_board;
		cfg_t              regs;
		logic [CoordW-1:0] last_x, last_y;
		logic [PosW-1:0]   pan, tilt;
		track_t            expected_tracks[$];
		int                errors;

		function new();
			regs.deadband     = 10'd10;
			regs.small_limit  = 10'd40;
			regs.medium_limit = 10'd100;
			regs.center_x     = 10'd500;
			regs.center_y     = 10'd362;
			regs.step_small   = 4'd1;
			regs.step_medium  = 4'd3;
			regs.step_large   = 4'd5;
			last_x = '0;
			last_y = '0;
			pan    = PanReset;
			tilt   = TiltReset;
			errors = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CfgDataW-1:0] value);
			case (idx)
				REG_DEADBAND:     regs.deadband     = value;
				REG_SMALL_LIMIT:  regs.small_limit  = value;
				REG_MEDIUM_LIMIT: regs.medium_limit = value;
				REG_CENTER_X:     regs.center_x     = value;
				REG_CENTER_Y:     regs.center_y     = value;
				REG_STEP_SMALL:   regs.step_small   = value[StepW-1:0];
				REG_STEP_MEDIUM:  regs.step_medium  = value[StepW-1:0];
				REG_STEP_LARGE:   regs.step_large   = value[StepW-1:0];
				default: ;
			endcase
		endfunction

		// limits are checked in priority order, even when misordered
		function logic [StepW-1:0] step_for(logic [CoordW-1:0] d);
			if (d <= regs.small_limit)
				return regs.step_small;
			if (d <= regs.medium_limit)
				return regs.step_medium;
			return regs.step_large;
		endfunction

		function logic [PosW-1:0] nudge(logic [PosW-1:0] pos, logic [StepW-1:0] st, bit up);
			int unsigned sum;
			sum = int'(pos) + int'(st);
			if (up)
				return (sum > PosMax) ? PosMax : sum[PosW-1:0];
			return (st > pos) ? '0 : pos - st;
		endfunction

		function void note_spot(spot_t s);
			track_t            r;
			logic [PosW-1:0]   old_pan, old_tilt;
			logic [CoordW-1:0] dx, dy;
			bit                present;
			old_pan  = pan;
			old_tilt = tilt;
			present  = !(s.spot_x == CoordMax && s.spot_y == CoordMax && s.spot_size == SizeNone);
			if (present) begin
				dx = (last_x > s.spot_x) ? last_x - s.spot_x : s.spot_x - last_x;
				dy = (last_y > s.spot_y) ? last_y - s.spot_y : s.spot_y - last_y;
				if (dx > regs.deadband && s.spot_x != 0 && s.spot_x != CoordMax) begin
					pan    = nudge(pan, step_for(dx), s.spot_x >= regs.center_x);
					last_x = s.spot_x;
				end
				if (!s.hold_vertical && dy > regs.deadband && s.spot_y != 0 && s.spot_y <= YLimit) begin
					tilt   = nudge(tilt, step_for(dy), s.spot_y < regs.center_y);
					last_y = s.spot_y;
				end
			end
			r.detected      = present;
			r.pan_position  = pan;
			r.tilt_position = tilt;
			r.pan_moved     = (pan != old_pan);
			r.tilt_moved    = (tilt != old_tilt);
			expected_tracks.push_back(r);
		endfunction

		function void check_track(track_t got);
			track_t want;
			if (expected_tracks.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: det=%0b pan=%0d tilt=%0d pm=%0b tm=%0b",
					$time, got.detected, got.pan_position, got.tilt_position,
					got.pan_moved, got.tilt_moved);
				return;
			end
			want = expected_tracks.pop_front();
			if (got.detected !== want.detected || got.pan_position !== want.pan_position ||
					got.tilt_position !== want.tilt_position || got.pan_moved !== want.pan_moved ||
					got.tilt_moved !== want.tilt_moved) begin
				errors++;
				$display("%0t: mismatch expected det=%0b pan=%0d tilt=%0d pm=%0b tm=%0b",
					$time, want.detected, want.pan_position, want.tilt_position,
					want.pan_moved, want.tilt_moved);
				$display("%0t:          actual   det=%0b pan=%0d tilt=%0d pm=%0b tm=%0b",
					$time, got.detected, got.pan_position, got.tilt_position,
					got.pan_moved, got.tilt_moved);
			end
		endfunction

		function int pending();
			return expected_tracks.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	spot_t               in_data;
	logic                out_valid;
	logic                out_stall;
	track_t              out_data;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	track_board board;
	int         idle_pct = 0;
	int         stall_pct = 0;
	bit         hold_req = 0;
	int         hold_left = 0;
	int         cycle_count = 0;
	int         sweep_left = 0;
	bit         sweep_x_up, sweep_y_up;

	ir_spot_pan_tilt_tracker DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_track(out_data);
	end

	// receiver: random stall, or a long hold-off when requested
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	function automatic spot_t mk_spot(int x, int y, int sz, bit hold);
		spot_t s;
		s.spot_x        = CoordW'(x);
		s.spot_y        = CoordW'(y);
		s.spot_size     = SizeW'(sz);
		s.hold_vertical = hold;
		return s;
	endfunction

	// pick a coordinate on one side of the center line, far or near the last accepted one
	function automatic logic [CoordW-1:0] pick_coord(int last, int center, int top, bit up);
		int lo, hi, v;
		lo = up ? center : 1;
		hi = up ? top : center - 1;
		if (hi < lo) begin
			lo = 1;
			hi = top;
		end
		if ($urandom_range(0, 1))
			v = $urandom_range(hi, lo);
		else
			v = last + int'($urandom_range(0, 300)) - 150;
		if (v < lo)
			v = lo;
		if (v > hi)
			v = hi;
		return v[CoordW-1:0];
	endfunction

	function automatic spot_t random_spot();
		spot_t s;
		int    r;
		r = $urandom_range(0, 99);
		s.spot_size     = SizeW'($urandom_range(0, 254));
		s.hold_vertical = ($urandom_range(0, 3) == 0);
		if (r < 8) begin
			s.spot_x    = CoordMax;
			s.spot_y    = CoordMax;
			s.spot_size = SizeNone;
		end else if (r < 16) begin
			s.spot_x    = CoordW'($urandom_range(0, 1023));
			s.spot_y    = CoordW'($urandom_range(0, 1023));
			s.spot_size = SizeW'($urandom_range(0, 255));
		end else if (r < 24) begin
			case ($urandom_range(0, 3))
				0: s.spot_x = '0;
				1: s.spot_x = 10'd1;
				2: s.spot_x = 10'd1022;
				default: s.spot_x = CoordMax;
			endcase
			case ($urandom_range(0, 4))
				0: s.spot_y = '0;
				1: s.spot_y = 10'd1;
				2: s.spot_y = YLimit;
				3: s.spot_y = YLimit + 10'd1;
				default: s.spot_y = CoordMax;
			endcase
			s.spot_size = $urandom_range(0, 1) ? SizeNone : 8'($urandom_range(250, 255));
		end else begin
			// sweep: stay on one side for a while so positions run into saturation
			if (sweep_left == 0) begin
				sweep_left = $urandom_range(30, 90);
				sweep_x_up = 1'($urandom_range(0, 1));
				sweep_y_up = 1'($urandom_range(0, 1));
			end
			sweep_left--;
			s.spot_x = pick_coord(int'(board.last_x), int'(board.regs.center_x), 1022,
				sweep_x_up);
			s.spot_y = pick_coord(int'(board.last_y), int'(board.regs.center_y), int'(YLimit),
				sweep_y_up);
		end
		return s;
	endfunction

	task automatic send_spot(spot_t s);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		do
			@(posedge clk);
		while (in_stall);
		board.note_spot(s);
	endtask

	task automatic pause_sending();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		board.set_reg(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_setting(int pick);
		logic [CfgDataW-1:0] vals[8];
		case (pick)
			0: vals = '{0, 0, 1023, 1, 1, 0, 15, 15};
			1: vals = '{1023, 1023, 1023, 1022, 768, 15, 15, 15};
			2: vals = '{3, 200, 50, 512, 384, 2, 7, 15};
			3: vals = '{5, 20, 60, 500, 362, 15, 15, 15};
			4: vals = '{10, 40, 100, 500, 362, 1, 3, 5};
			default: begin
				vals[0] = CfgDataW'($urandom_range(0, 40));
				vals[1] = CfgDataW'($urandom_range(0, 120));
				vals[2] = CfgDataW'($urandom_range(0, 300));
				vals[3] = CfgDataW'($urandom_range(1, 1022));
				vals[4] = CfgDataW'($urandom_range(1, 768));
				vals[5] = CfgDataW'($urandom_range(0, 15));
				vals[6] = CfgDataW'($urandom_range(0, 15));
				vals[7] = CfgDataW'($urandom_range(0, 15));
			end
		endcase
		for (int i = 0; i < 8; i++)
			write_reg(cfg_reg_t'(i), vals[i]);
	endtask

	initial begin
		spot_t directed[$];
		board     = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: no-spot marker, deadband and limit edges, windows, center lines, hold
		directed = '{
			mk_spot(1023, 1023, 255, 0), mk_spot(1023, 1023, 255, 1),
			mk_spot(10, 10, 0, 0), mk_spot(11, 11, 0, 0), mk_spot(51, 51, 1, 0),
			mk_spot(92, 92, 2, 0), mk_spot(192, 192, 4, 0), mk_spot(293, 293, 8, 0),
			mk_spot(500, 362, 16, 0), mk_spot(499, 361, 32, 0), mk_spot(0, 0, 64, 0),
			mk_spot(1023, 768, 128, 0), mk_spot(1023, 1023, 254, 0), mk_spot(1022, 769, 255, 0),
			mk_spot(1023, 1022, 255, 1), mk_spot(1022, 1023, 255, 0), mk_spot(100, 100, 170, 1),
			mk_spot(499, 361, 85, 0), mk_spot(200, 500, 255, 1), mk_spot(700, 1, 0, 0),
			mk_spot(1, 767, 255, 0)
		};
		foreach (directed[i])
			send_spot(directed[i]);
		pause_sending();
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 62; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 62; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			for (int chunk = 0; chunk < 4; chunk++) begin
				load_setting(phase * 4 + chunk);
				if (phase == 0 && chunk == 1) begin
					// hold the receiver off while items keep coming, so the input backs up
					@(posedge clk);
					hold_req = 1;
				end
				repeat (50) send_spot(random_spot());
				pause_sending();
				drain();
			end
		end

		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
